[sv/i2cbc_pkg.sv]
package i2cbc_pkg;

    localparam int ERR_W      = 8;
    localparam int HALF_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_PULSES_DEF = 9;

    localparam logic [ERR_W-1:0]  ERR_MAX_RST     = 8'd3;
    localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 16'd10;
    localparam logic [ERR_W-1:0]  ERR_SAT         = 8'd255;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ERROR  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_VERIFY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        OUT_NONE      = 2'd0,
        OUT_RECOVERED = 2'd1,
        OUT_DAMAGED   = 2'd2
    } outcome_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ERR_MAX     = 1'd0,
        CFG_HALF_PERIOD = 1'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SAMPLE,
        PH_PULSE_LO,
        PH_PULSE_HI,
        PH_STOP_LO,
        PH_STOP_SCL,
        PH_STOP_SDA
    } phase_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       ok;
        logic [1:0] outcome;
    } res_t;

endpackage

[sv/i2c_bus_clear_sequencer.sv]
// I2C bus clear sequencer.
//
// Input channel (in_valid / in_stall, op, sda_in): one request per tick or
// event. op is tick, error report, clear count or verify. sda_in is the
// sampled SDA level, used only while a bus clear runs.
// Output channel (out_valid / out_stall): exactly one result per request,
// carrying the SCL/SDA drive levels after that request, busy flag,
// verify answer and the outcome of a finished clear.
// Config port (cfg_we, cfg_index, cfg_data): index 0 err_max, index 1
// half_period. Write only while idle.
//
// Results are registered. Throughput: one request per cycle unless
// in_stall is high; the state update is a single level of
// compare/decrement logic between the request and the result register.
// A two-entry output stage (result register plus skid register) lets a new
// request be taken while a result waits; in_stall rises only when both
// entries hold results, and drops once the receiver takes one.
// Reset (rst_n low, async): count zero, idle, both lines released,
// err_max = 3, half_period = 10, output stage empty.
module i2c_bus_clear_sequencer #(
    parameter int MAX_PULSES = i2cbc_pkg::MAX_PULSES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       op,
    input  logic                             sda_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             scl_level,
    output logic                             sda_level,
    output logic                             busy_res,
    output logic                             verify_ok,
    output logic [1:0]                       outcome,
    input  logic                             cfg_we,
    input  logic [i2cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i2cbc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import i2cbc_pkg::*;

    localparam int PULSE_W = $clog2(MAX_PULSES + 1);
    localparam logic [PULSE_W-1:0] PULSE_LAST = PULSE_W'(MAX_PULSES);

    // config
    logic [ERR_W-1:0]  err_max_reg;
    logic [HALF_W-1:0] half_period_reg;

    // sequencer state
    logic [ERR_W-1:0]   error_count_reg, error_count_next;
    phase_t             phase_reg, phase_next;
    logic [PULSE_W-1:0] pulse_count_reg, pulse_count_next;
    logic [HALF_W-1:0]  hold_timer_reg, hold_timer_next;
    logic               freed_reg, freed_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;

    // output stage
    logic out_valid_reg, skid_valid_reg;
    res_t out_reg, skid_reg;
    res_t res;

    logic              accept, out_fire, level_done;
    logic [HALF_W-1:0] hold_len;
    op_t               op_in;

    assign op_in    = op_t'(op);
    assign accept   = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;
    assign hold_len = (half_period_reg == '0) ? HALF_W'(1) : half_period_reg;
    assign level_done = (hold_timer_reg <= HALF_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_max_reg     <= ERR_MAX_RST;
            half_period_reg <= HALF_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ERR_MAX:     err_max_reg     <= cfg_data[ERR_W-1:0];
                CFG_HALF_PERIOD: half_period_reg <= cfg_data[HALF_W-1:0];
                default:         ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        error_count_next = error_count_reg;
        phase_next       = phase_reg;
        pulse_count_next = pulse_count_reg;
        hold_timer_next  = hold_timer_reg;
        freed_next       = freed_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;

        case (phase_reg)
            PH_IDLE:
            begin
                scl_next = 1'b1;
                sda_next = 1'b1;
                case (op_in)
                    OP_ERROR:
                        if (error_count_reg != ERR_SAT)
                            error_count_next = error_count_reg + ERR_W'(1);
                    OP_CLEAR:
                        error_count_next = '0;
                    OP_VERIFY:
                        if (error_count_reg >= err_max_reg)
                        begin
                            phase_next       = PH_SAMPLE;
                            pulse_count_next = '0;
                            freed_next       = 1'b0;
                            hold_timer_next  = '0;
                        end
                    default: ;
                endcase
            end
            PH_SAMPLE, PH_PULSE_HI:
            begin
                if (phase_reg == PH_SAMPLE || level_done)
                begin
                    if (phase_reg == PH_PULSE_HI)
                        pulse_count_next = pulse_count_reg + PULSE_W'(1);
                    hold_timer_next = hold_len;
                    if (sda_in)
                    begin
                        freed_next = 1'b1;
                        phase_next = PH_STOP_LO;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                    end
                    else if (pulse_count_next >= PULSE_LAST)
                    begin
                        phase_next = PH_STOP_LO;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_PULSE_LO;
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                    end
                end
                else
                    hold_timer_next = hold_timer_reg - HALF_W'(1);
            end
            PH_PULSE_LO, PH_STOP_LO, PH_STOP_SCL:
            begin
                if (level_done)
                begin
                    hold_timer_next = hold_len;
                    scl_next        = 1'b1;
                    case (phase_reg)
                        PH_PULSE_LO:
                        begin
                            phase_next = PH_PULSE_HI;
                            sda_next   = 1'b1;
                        end
                        PH_STOP_LO:
                        begin
                            phase_next = PH_STOP_SCL;
                            sda_next   = 1'b0;
                        end
                        default:
                        begin
                            phase_next = PH_STOP_SDA;
                            sda_next   = 1'b1;
                        end
                    endcase
                end
                else
                    hold_timer_next = hold_timer_reg - HALF_W'(1);
            end
            default: // STOP_SDA
            begin
                if (level_done)
                begin
                    if (freed_reg || sda_in)
                        error_count_next = '0;
                    phase_next      = PH_IDLE;
                    hold_timer_next = '0;
                    scl_next        = 1'b1;
                    sda_next        = 1'b1;
                end
                else
                    hold_timer_next = hold_timer_reg - HALF_W'(1);
            end
        endcase
    end

    // result for this request
    always_comb
    begin
        res.scl     = scl_next;
        res.sda     = sda_next;
        res.busy    = (phase_next != PH_IDLE);
        res.ok      = (phase_reg == PH_IDLE) && (op_in == OP_VERIFY)
                      && (error_count_reg < err_max_reg);
        res.outcome = OUT_NONE;
        if (phase_reg == PH_STOP_SDA && level_done)
            res.outcome = (!freed_reg && !sda_in) ? OUT_DAMAGED : OUT_RECOVERED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_count_reg <= '0;
            phase_reg       <= PH_IDLE;
            pulse_count_reg <= '0;
            hold_timer_reg  <= '0;
            freed_reg       <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
        end
        else if (accept)
        begin
            error_count_reg <= error_count_next;
            phase_reg       <= phase_next;
            pulse_count_reg <= pulse_count_next;
            hold_timer_reg  <= hold_timer_next;
            freed_reg       <= freed_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
        end
    end

    // output register + skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_fire)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_level = out_reg.scl;
    assign sda_level = out_reg.sda;
    assign busy_res  = out_reg.busy;
    assign verify_ok = out_reg.ok;
    assign outcome   = out_reg.outcome;

endmodule

[dv/bus_clear_checker.sv]
module bus_clear_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [1:0]                       op,
    input  logic                             sda_in,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             scl_level,
    input  logic                             sda_level,
    input  logic                             busy_res,
    input  logic                             verify_ok,
    input  logic [1:0]                       outcome,
    input  logic                             cfg_we,
    input  logic [i2cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i2cbc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                               bad_results,
    output int                               results_due
);
    import i2cbc_pkg::*;

    // register copies
    logic [ERR_W-1:0]  thr;
    logic [HALF_W-1:0] half_len;

    // sequencer state
    logic [ERR_W-1:0]  err_cnt;
    phase_t            ph;
    logic [3:0]        pulses;
    logic [HALF_W-1:0] hold;
    logic              freed;
    logic              scl_q;
    logic              sda_q;

    res_t              due_q[$];
    res_t              got;
    res_t              want;
    int                n_bad;

    // start holding a new line level; zero half period acts as one
    function automatic void enter_level(phase_t nxt, logic scl, logic sda);
        ph    = nxt;
        hold  = (half_len == '0) ? HALF_W'(1) : half_len;
        scl_q = scl;
        sda_q = sda;
    endfunction

    // sample slot: SDA high or pulse budget spent -> STOP, else one more pulse
    function automatic void sample_sda(logic sda);
        if (sda || pulses >= MAX_PULSES_DEF)
        begin
            freed = freed | sda;
            enter_level(PH_STOP_LO, 1'b0, 1'b0);
        end
        else
        begin
            enter_level(PH_PULSE_LO, 1'b0, 1'b1);
        end
    endfunction

    function automatic logic hold_elapsed();
        if (hold > 1)
        begin
            hold = hold - 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic res_t bus_clear_step(op_t rq, logic sda);
        res_t     r;
        logic     ok;
        outcome_t oc;
        ok = 1'b0;
        oc = OUT_NONE;
        case (ph)
            PH_IDLE:
            begin
                scl_q = 1'b1;
                sda_q = 1'b1;
                case (rq)
                    OP_ERROR:
                        if (err_cnt != ERR_SAT)
                            err_cnt = err_cnt + 1'b1;
                    OP_CLEAR:
                        err_cnt = '0;
                    OP_VERIFY:
                        if (err_cnt < thr)
                            ok = 1'b1;
                        else
                        begin
                            ph     = PH_SAMPLE;
                            pulses = '0;
                            freed  = 1'b0;
                            hold   = '0;
                        end
                    default: ;
                endcase
            end
            PH_SAMPLE:
                sample_sda(sda);
            PH_PULSE_LO:
                if (hold_elapsed())
                    enter_level(PH_PULSE_HI, 1'b1, 1'b1);
            PH_PULSE_HI:
                if (hold_elapsed())
                begin
                    pulses = pulses + 1'b1;
                    sample_sda(sda);
                end
            PH_STOP_LO:
                if (hold_elapsed())
                    enter_level(PH_STOP_SCL, 1'b1, 1'b0);
            PH_STOP_SCL:
                if (hold_elapsed())
                    enter_level(PH_STOP_SDA, 1'b1, 1'b1);
            default:
                if (hold_elapsed())
                begin
                    if (!freed && !sda)
                        oc = OUT_DAMAGED;
                    else
                    begin
                        oc      = OUT_RECOVERED;
                        err_cnt = '0;
                    end
                    ph    = PH_IDLE;
                    hold  = '0;
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                end
        endcase
        r.scl     = scl_q;
        r.sda     = sda_q;
        r.busy    = (ph != PH_IDLE);
        r.ok      = ok;
        r.outcome = oc;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr      = ERR_MAX_RST;
            half_len = HALF_PERIOD_RST;
            err_cnt  = '0;
            ph       = PH_IDLE;
            pulses   = '0;
            hold     = '0;
            freed    = 1'b0;
            scl_q    = 1'b1;
            sda_q    = 1'b1;
            due_q.delete();
            n_bad    = 0;
            bad_results <= 0;
            results_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ERR_MAX:     thr = cfg_data[ERR_W-1:0];
                    CFG_HALF_PERIOD: half_len = cfg_data[HALF_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                due_q.push_back(bus_clear_step(op_t'(op), sda_in));
            if (out_valid && !out_stall)
            begin
                got = {scl_level, sda_level, busy_res, verify_ok, outcome};
                if (due_q.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: unexpected result scl=%b sda=%b busy=%b ok=%b outcome=%0d",
                                 $realtime, got.scl, got.sda, got.busy, got.ok, got.outcome);
                end
                else
                begin
                    want = due_q.pop_front();
                    if (got !== want)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"%0t: result mismatch exp scl=%b sda=%b busy=%b ok=%b ",
                                      "outcome=%0d got scl=%b sda=%b busy=%b ok=%b outcome=%0d"},
                                     $realtime, want.scl, want.sda, want.busy, want.ok,
                                     want.outcome, got.scl, got.sda, got.busy, got.ok,
                                     got.outcome);
                    end
                end
            end
            bad_results <= n_bad;
            results_due <= due_q.size();
        end
    end

endmodule

[dv/tb.sv]
module tb;
    import i2cbc_pkg::*;

    localparam int LONG_HOLD = 60;     // receiver hold-off in the pressure phase
    localparam int DRAIN_CAP = 20000;  // cycles allowed for the last results

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [1:0]            op        = OP_TICK;
    logic                  sda_in    = 1'b1;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ERR_MAX;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  in_stall;
    logic                  out_valid;
    logic                  scl_level;
    logic                  sda_level;
    logic                  busy_res;
    logic                  verify_ok;
    logic [1:0]            outcome;

    int                    bad_results;
    int                    results_due;

    // traffic shaping
    int                    idle_pct   = 0;   // sender gap odds, top process only
    int                    stall_pct  = 0;   // receiver stall odds, set with <=
    int                    sda_hi_pct = 20;  // odds of SDA seen high on a request
    logic                  press_on   = 1'b0;
    logic                  press_seen = 1'b0;
    int                    hold_left  = 0;
    logic [HALF_W-1:0]     cur_half   = HALF_PERIOD_RST;
    int                    waited;

    always #1 clk = ~clk;

    i2c_bus_clear_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .sda_in    (sda_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .scl_level (scl_level),
        .sda_level (sda_level),
        .busy_res  (busy_res),
        .verify_ok (verify_ok),
        .outcome   (outcome),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bus_clear_checker i_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .sda_in      (sda_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .scl_level   (scl_level),
        .sda_level   (sda_level),
        .busy_res    (busy_res),
        .verify_ok   (verify_ok),
        .outcome     (outcome),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .bad_results (bad_results),
        .results_due (results_due)
    );

    // Receiver: random stalls at stall_pct. When the pressure phase opens, it
    // holds off without a break while it counts down LONG_HOLD, so the output
    // stage fills and the block has to stall its request side.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (press_on && !press_seen)
        begin
            out_stall <= 1'b1;
            hold_left <= LONG_HOLD;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
        press_seen <= press_on;
    end

    // Offer one request and return at the edge where it is taken. Valid goes
    // low only during a random gap, so back-to-back requests keep it high.
    task automatic offer(input op_t rq, input logic s);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= rq;
        sda_in   <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop offering and wait until every request has its result back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Both registers, only while idle (caller's duty, unchecked). The unused top
    // bits of the threshold write carry noise; only the low byte counts.
    task automatic configure(input logic [ERR_W-1:0] t, input logic [HALF_W-1:0] h);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ERR_MAX;
        cfg_data  <= {8'($urandom), t};
        @(posedge clk);
        cfg_index <= CFG_HALF_PERIOD;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_half  = h;
    endtask

    // Ticks with SDA high: any clear in flight finishes its pulse, sees SDA
    // high and runs the STOP, so the sequencer is idle afterwards.
    task automatic flush_clear();
        int n;
        n = 5 * ((cur_half == 0) ? 1 : int'(cur_half)) + 6;
        repeat (n) offer(OP_TICK, 1'b1);
    endtask

    // Weighted toward error reports and verifies so the count keeps crossing
    // the threshold and clears start often; ops during a clear are ignored.
    task automatic random_burst(input int n);
        int  r;
        op_t rq;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 35)
                rq = OP_TICK;
            else if (r < 65)
                rq = OP_ERROR;
            else if (r < 72)
                rq = OP_CLEAR;
            else
                rq = OP_VERIFY;
            offer(rq, $urandom_range(99) < sda_hi_pct);
        end
    endtask

    task automatic run_phase(input logic [ERR_W-1:0] t, input logic [HALF_W-1:0] h,
                             input int idle, input int stall, input int sda_hi,
                             input int n, input logic press);
        configure(t, h);
        idle_pct   = idle;
        sda_hi_pct = sda_hi;
        stall_pct <= stall;
        press_on  <= press;
        random_burst(n);
        flush_clear();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings (threshold 3, half period 10).
        offer(OP_VERIFY, 1'b0);          // count 0: ok
        offer(OP_ERROR, 1'b0);
        offer(OP_CLEAR, 1'b0);           // back to 0
        offer(OP_ERROR, 1'b1);
        offer(OP_ERROR, 1'b0);
        offer(OP_VERIFY, 1'b1);          // count 2: ok
        offer(OP_ERROR, 1'b0);
        offer(OP_VERIFY, 1'b0);          // count 3: clear starts
        offer(OP_ERROR, 1'b0);           // first sample, SDA low -> pulse
        offer(OP_CLEAR, 1'b0);           // ignored while busy
        offer(OP_VERIFY, 1'b0);          // ignored, no ok
        flush_clear();

        // Zero threshold and zero half period: verify at count 0 starts a
        // clear; SDA held low through all pulses and the final check -> damaged.
        configure('0, '0);
        offer(OP_VERIFY, 1'b0);
        repeat (24) offer(op_t'($urandom_range(3)), 1'b0);

        // Threshold 1, shortest levels: SDA comes free after a few pulses.
        configure(8'd1, 16'd1);
        offer(OP_ERROR, 1'b0);
        offer(OP_VERIFY, 1'b0);
        repeat (5) offer(OP_TICK, 1'b0);
        flush_clear();
        offer(OP_VERIFY, 1'b0);          // count cleared by recovery: ok

        // Largest threshold and count saturation.
        configure(8'd255, 16'd1);
        repeat (254) offer(OP_ERROR, 1'($urandom));
        offer(OP_VERIFY, 1'b0);          // 254 below 255: ok
        repeat (4) offer(OP_ERROR, 1'($urandom));
        offer(OP_VERIFY, 1'b0);          // stuck at 255: clear starts
        flush_clear();

        // Random phases: no idling, sender gaps, receiver stalls, both, and
        // the long receiver hold-off with the sender at full rate.
        run_phase(8'd2, 16'd1,  0,  0, 15, 30, 1'b0);
        run_phase(8'd1, 16'd2, 76,  0, 30, 30, 1'b0);
        run_phase(8'd4, 16'd1,  0, 76,  5, 30, 1'b0);
        run_phase(8'd3, 16'd3, 29, 29, 20, 30, 1'b0);
        run_phase(8'd2, 16'd1,  0,  0, 10, 30, 1'b1);

        // Drain with a bound, then the verdict.
        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (results_due != 0 && waited < DRAIN_CAP)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (bad_results == 0 && results_due == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial
    begin
        #200000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

[i2c_bus_clear_sequencer.f]
sv/i2cbc_pkg.sv
sv/i2c_bus_clear_sequencer.sv
dv/bus_clear_checker.sv
dv/tb.sv
